@@ hw/rtl/dollar_escape_line_decoder_top_defines.svh @@
// assertion macros for the dollar escape line decoder
// used by dled_step and dled_rsp_queue; no other dependencies
`ifndef DOLLAR_ESCAPE_LINE_DECODER_TOP_DEFINES_SVH
`define DOLLAR_ESCAPE_LINE_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DLED_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dled assertion failed");
`define DLED_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dled assertion failed");
`else
`define DLED_ASSERT_IMP(label, clk, rst, ante, cons)
`define DLED_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/dled_pkg.sv @@
// shared types and constants for the dollar escape line decoder
// no dependencies
`timescale 1ns / 1ps

package dled_pkg;

   localparam int MAX_LINE_DEFAULT = 4096;
   localparam int CSR_W            = 13;
   localparam logic [CSR_W-1:0] MAX_LINE_LEN_RESET = 13'd256;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_EOL  = 2'd1;
   localparam logic [1:0] KIND_EOF  = 2'd2;
   localparam logic [1:0] KIND_LONG = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] kind;
      logic       last;
   } result_type;

   // up to two results per input item
   typedef struct packed {
      logic [1:0] num;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

@@ hw/rtl/dled_step.sv @@
// input register, decoder state and the single pass escape decode
// depends on dled_pkg and dollar_escape_line_decoder_top_defines.svh
`timescale 1ns / 1ps
`include "dollar_escape_line_decoder_top_defines.svh"

module dled_step #(
   parameter int MAX_LINE = dled_pkg::MAX_LINE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [dled_pkg::CSR_W-1:0] max_line_len,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [7:0]                 in_byte,
   input  logic                       at_end,
   input  logic                       room,
   output dled_pkg::push_type         push
);

   localparam int CNT_W = $clog2(MAX_LINE + 1);
   localparam int CMP_W = (CNT_W > dled_pkg::CSR_W) ? CNT_W : dled_pkg::CSR_W;

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_BODY   = 2'd1;
   localparam logic [1:0] MODE_DOLLAR = 2'd2;
   localparam logic [1:0] MODE_HEX    = 2'd3;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_end_ff;
   logic [1:0]       mode_ff, mode_in;
   logic [3:0]       hi_ff, hi_in;
   logic [CNT_W-1:0] line_count_ff, line_count_in;
   logic             halted_ff, halted_in;

   logic             go;
   logic             accept;
   logic             hex_ok;
   logic [3:0]       hex_nib;
   logic [CMP_W-1:0] limit;
   logic             do_data0;
   logic [7:0]       data0_val;
   logic             do_body;
   logic             body_put;
   dled_pkg::result_type body_res;

   assign go       = in_valid_ff && room;
   assign in_ready = !in_valid_ff || room;
   assign accept   = in_valid && in_ready;
   assign in_valid_in = accept || (in_valid_ff && !go);

   assign limit = (CMP_W'(max_line_len) > CMP_W'(MAX_LINE)) ? CMP_W'(MAX_LINE)
                                                            : CMP_W'(max_line_len);

   always_comb begin
      hex_ok  = 1'b1;
      hex_nib = 4'h0;
      if (in_byte_ff >= 8'h30 && in_byte_ff <= 8'h39) begin
         hex_nib = 4'(in_byte_ff - 8'h30);
      end else if (in_byte_ff >= 8'h41 && in_byte_ff <= 8'h46) begin
         hex_nib = 4'(in_byte_ff - 8'h37);
      end else if (in_byte_ff >= 8'h61 && in_byte_ff <= 8'h66) begin
         hex_nib = 4'(in_byte_ff - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      hi_in         = hi_ff;
      line_count_in = line_count_ff;
      halted_in     = halted_ff;
      push          = '0;
      do_data0      = 1'b0;
      data0_val     = 8'h00;
      do_body       = 1'b0;
      body_put      = 1'b0;
      body_res      = '0;
      if (go && !halted_ff) begin
         if (in_end_ff) begin
            push.num  = 2'd1;
            push.r0   = '{data_byte: 8'h00, kind: dled_pkg::KIND_EOF, last: 1'b1};
            halted_in = 1'b1;
         end else begin
            unique case (mode_ff)
               MODE_START: begin
                  do_body = !(in_byte_ff == CHAR_SPACE || in_byte_ff == CHAR_TAB ||
                              in_byte_ff == CHAR_NL);
               end
               MODE_BODY: begin
                  do_body = 1'b1;
               end
               MODE_DOLLAR: begin
                  if (in_byte_ff == CHAR_N) begin
                     do_data0  = 1'b1;
                     data0_val = CHAR_NL;
                  end else if (in_byte_ff == CHAR_T) begin
                     do_data0  = 1'b1;
                     data0_val = CHAR_TAB;
                  end else if (hex_ok) begin
                     hi_in   = hex_nib;
                     mode_in = MODE_HEX;
                  end else if (in_byte_ff == CHAR_NL) begin
                     mode_in = MODE_START;
                  end else begin
                     do_data0  = 1'b1;
                     data0_val = in_byte_ff;
                  end
               end
               MODE_HEX: begin
                  do_data0 = 1'b1;
                  if (hex_ok) begin
                     data0_val = {hi_ff, hex_nib};
                  end else begin
                     // lone digit, then the byte is handled as text
                     data0_val = {4'h0, hi_ff};
                     do_body   = 1'b1;
                  end
               end
               default: begin
                  mode_in = MODE_START;
               end
            endcase

            if (do_data0) begin
               push.num = 2'd1;
               if (CMP_W'(line_count_ff) >= limit) begin
                  push.r0   = '{data_byte: 8'h00, kind: dled_pkg::KIND_LONG, last: 1'b0};
                  halted_in = 1'b1;
                  do_body   = 1'b0;
               end else begin
                  push.r0       = '{data_byte: data0_val, kind: dled_pkg::KIND_DATA,
                                    last: 1'b0};
                  line_count_in = line_count_ff + CNT_W'(1);
                  mode_in       = MODE_BODY;
               end
            end

            if (do_body) begin
               if (in_byte_ff == CHAR_DOLLAR) begin
                  mode_in = MODE_DOLLAR;
               end else if (in_byte_ff == CHAR_NL) begin
                  body_put      = 1'b1;
                  body_res      = '{data_byte: 8'h00, kind: dled_pkg::KIND_EOL, last: 1'b0};
                  line_count_in = '0;
                  mode_in       = MODE_START;
               end else if (CMP_W'(line_count_in) >= limit) begin
                  body_put  = 1'b1;
                  body_res  = '{data_byte: 8'h00, kind: dled_pkg::KIND_LONG, last: 1'b0};
                  halted_in = 1'b1;
               end else begin
                  body_put      = 1'b1;
                  body_res      = '{data_byte: in_byte_ff, kind: dled_pkg::KIND_DATA,
                                    last: 1'b0};
                  line_count_in = line_count_in + CNT_W'(1);
                  mode_in       = MODE_BODY;
               end
            end

            if (body_put) begin
               if (push.num == 2'd0) begin
                  push.r0 = body_res;
               end else begin
                  push.r1 = body_res;
               end
               push.num = push.num + 2'd1;
            end

            if (push.num == 2'd1) begin
               push.r0.last = 1'b1;
            end else if (push.num == 2'd2) begin
               push.r1.last = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mode_ff       <= MODE_START;
         hi_ff         <= 4'h0;
         line_count_ff <= '0;
         halted_ff     <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         mode_ff       <= mode_in;
         hi_ff         <= hi_in;
         line_count_ff <= line_count_in;
         halted_ff     <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= in_byte;
         in_end_ff  <= at_end;
      end
   end

   `DLED_ASSERT_NXT(a_halt_sticky, clock, reset, halted_ff, halted_ff)
   `DLED_ASSERT_IMP(a_halt_silent, clock, reset, halted_ff, push.num == 2'd0)
   `DLED_ASSERT_IMP(a_push_needs_go, clock, reset, push.num != 2'd0, go)

endmodule

@@ hw/rtl/dled_rsp_queue.sv @@
// four entry result queue, takes up to two results and gives one per cycle while out_ready is high
// depends on dled_pkg and dollar_escape_line_decoder_top_defines.svh
`timescale 1ns / 1ps
`include "dollar_escape_line_decoder_top_defines.svh"

module dled_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  dled_pkg::push_type   push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dled_pkg::result_type out_res
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dled_pkg::result_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_ptr_next;

   assign room        = count_ff <= CNT_W'(DEPTH - 2);
   assign out_valid   = count_ff != '0;
   assign out_res     = entry_ff[rd_ptr_ff];
   assign pop         = out_valid && out_ready;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.r1;
      end
   end

   `DLED_ASSERT_IMP(a_no_overflow, clock, reset, push.num != 2'd0,
                    count_ff <= CNT_W'(DEPTH - 2))
   `DLED_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

endmodule

@@ hw/rtl/dollar_escape_line_decoder_top.sv @@
// top level of the dollar escape line decoder: stream ports and config register
// depends on dled_pkg, dled_step and dled_rsp_queue
`timescale 1ns / 1ps

// Takes one raw text byte per item and returns decoded logical lines as data
// items closed by an end-of-line item (tuser kind 1); premature end (kind 2)
// or an overlong line (kind 3) halts the block until reset. A new input item
// is taken every cycle as long as the four-entry result queue has two free
// slots; a taken item waits in the input register until the queue has room,
// is then decoded, and its results go through the result queue to the rsp
// side. An item that yields two results (a lone hex digit followed by text)
// writes both at once; the sustained rate is one item per cycle while
// rsp_tready is high, bounded by one result per cycle on the rsp side.
// max_line_len is written via csr_wr_en and csr_wr_data, capped at MAX_LINE.
module dollar_escape_line_decoder_top #(
   parameter int MAX_LINE = dled_pkg::MAX_LINE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // in_byte
   input  logic                       req_tuser,   // at_end
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // out_byte
   output logic [1:0]                 rsp_tuser,   // kind
   output logic                       rsp_tlast,
   input  logic                       csr_wr_en,
   input  logic [dled_pkg::CSR_W-1:0] csr_wr_data
);

   logic [dled_pkg::CSR_W-1:0] max_line_len_ff;
   logic [dled_pkg::CSR_W-1:0] max_line_len_in;
   logic                       room;
   dled_pkg::push_type         push;
   dled_pkg::result_type       out_res;

   assign max_line_len_in = csr_wr_en ? csr_wr_data : max_line_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_len_ff <= dled_pkg::MAX_LINE_LEN_RESET;
      end else begin
         max_line_len_ff <= max_line_len_in;
      end
   end

   dled_step #(
      .MAX_LINE (MAX_LINE)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .max_line_len (max_line_len_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_byte      (req_tdata),
      .at_end       (req_tuser),
      .room         (room),
      .push         (push)
   );

   dled_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = out_res.data_byte;
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last;

endmodule
